// File: hdl/cscp_pkg.sv
// shared types and constants for the circle versus wall push-out pipeline
package cscp_pkg;

  localparam int QW = 12;           // quotient bits, one per divider stage
  localparam int NW = 31;           // dividend width
  localparam int DW = 19;           // divisor width (length below radius*256)
  localparam int LW = 25;           // full octagonal length width
  localparam int RW = 11;           // radius width
  localparam logic [LW-1:0] LEN_MIN = LW'(256);
  localparam logic [LW-1:0] K_S = LW'(164);
  localparam logic [LW-1:0] K_T = LW'(72);
  localparam logic [LW-1:0] K_S2 = LW'(15);
  localparam logic [LW-1:0] K_T2 = LW'(34);
  localparam logic [RW:0] PUSH_PAD = (RW+1)'(4);
  localparam logic [RW-1:0] RADIUS_RST = RW'(240);

  typedef struct packed {
    logic signed [15:0] cam_x;
    logic signed [15:0] cam_y;
    logic signed [11:0] start_x;
    logic signed [11:0] start_y;
    logic signed [11:0] end_x;
    logic signed [11:0] end_y;
  } in_beat_t;

  typedef struct packed {
    logic              hit;
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;
  } out_beat_t;

  typedef struct packed {
    logic signed [15:0] cam_x;
    logic signed [15:0] cam_y;
    logic signed [15:0] xp;
    logic signed [15:0] yp;
    logic signed [15:0] lx;
    logic signed [15:0] ly;
  } geo_t;

  typedef struct packed {
    logic              hit;
    logic              point;
    logic signed [15:0] base_x;
    logic signed [15:0] base_y;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
  } cls_t;

  typedef struct packed {
    cls_t        c;
    logic [15:0] a;
    logic [15:0] b;
    logic [16:0] s;
    logic [15:0] t;
  } st_t;

  typedef struct packed {
    cls_t          c;
    logic [15:0]   a;
    logic [15:0]   b;
    logic [LW-1:0] len;
  } len_t;

  typedef struct packed {
    logic              hit;
    logic              push;
    logic signed [15:0] base_x;
    logic signed [15:0] base_y;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [NW-1:0]     rem_x;
    logic [NW-1:0]     rem_y;
    logic [DW-1:0]     den;
    logic [QW-1:0]     q_x;
    logic [QW-1:0]     q_y;
  } div_t;

endpackage

// File: hdl/cscp_classify.sv
// wall offsets and hit classification, two stages
module cscp_classify (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [cscp_pkg::RW-1:0]  radius,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  cscp_pkg::in_beat_t       in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output cscp_pkg::cls_t           out_data
);

  cscp_pkg::geo_t geo;
  cscp_pkg::geo_t geo_next;
  cscp_pkg::cls_t cls;
  cscp_pkg::cls_t cls_next;
  logic v0;
  logic v1;
  logic en0;
  logic en1;

  logic signed [17:0] rs, nr, x18, y18, lx18, ly18, dh18, dv18, cx18, cy18;
  logic signed [15:0] dh, dv;

  assign en1 = !v1 || out_ready;
  assign en0 = !v0 || en1;
  assign in_ready = en0;
  assign out_valid = v1;
  assign out_data = cls;

  always_comb begin
    geo_next.cam_x = in_data.cam_x;
    geo_next.cam_y = in_data.cam_y;
    geo_next.xp = in_data.cam_x - {in_data.start_x, 4'b0};
    geo_next.yp = in_data.cam_y - {in_data.start_y, 4'b0};
    geo_next.lx = {in_data.end_x, 4'b0} - {in_data.start_x, 4'b0};
    geo_next.ly = {in_data.end_y, 4'b0} - {in_data.start_y, 4'b0};
  end

  always_comb begin
    rs = $signed({7'b0, radius});
    nr = -rs;
    x18 = 18'(geo.xp);
    y18 = 18'(geo.yp);
    lx18 = 18'(geo.lx);
    ly18 = 18'(geo.ly);
    cx18 = 18'(geo.cam_x);
    cy18 = 18'(geo.cam_y);
    dh = geo.xp - geo.lx;
    dv = geo.yp - geo.ly;
    dh18 = 18'(dh);
    dv18 = 18'(dv);
    cls_next.hit = 1'b0;
    cls_next.point = 1'b0;
    cls_next.base_x = geo.cam_x;
    cls_next.base_y = geo.cam_y;
    cls_next.dx = geo.xp;
    cls_next.dy = geo.yp;
    if (geo.ly == 16'sd0) begin
      if (y18 > nr && y18 < rs) begin
        if (lx18 > 18'sd0) begin
          if (x18 <= 18'sd0) begin
            if (x18 > nr) begin
              cls_next.hit = 1'b1;
              cls_next.point = 1'b1;
            end
          end else if (x18 >= lx18) begin
            if (dh18 < rs) begin
              cls_next.hit = 1'b1;
              cls_next.point = 1'b1;
              cls_next.dx = dh;
            end
          end else begin
            cls_next.hit = 1'b1;
            cls_next.base_y = 16'(cy18 + nr - y18);
          end
        end else begin
          if (x18 >= 18'sd0) begin
            if (x18 < rs) begin
              cls_next.hit = 1'b1;
              cls_next.point = 1'b1;
            end
          end else if (x18 <= lx18) begin
            if (dh18 > nr) begin
              cls_next.hit = 1'b1;
              cls_next.point = 1'b1;
              cls_next.dx = dh;
            end
          end else begin
            cls_next.hit = 1'b1;
            cls_next.base_y = 16'(cy18 + rs - y18);
          end
        end
      end
    end else if (geo.lx == 16'sd0) begin
      if (x18 > nr && x18 < rs) begin
        if (ly18 > 18'sd0) begin
          if (y18 <= 18'sd0) begin
            if (y18 > nr) begin
              cls_next.hit = 1'b1;
              cls_next.point = 1'b1;
            end
          end else if (y18 >= ly18) begin
            if (dv18 < rs) begin
              cls_next.hit = 1'b1;
              cls_next.point = 1'b1;
              cls_next.dy = dv;
            end
          end else begin
            cls_next.hit = 1'b1;
            cls_next.base_x = 16'(cx18 + rs - x18);
          end
        end else begin
          if (y18 >= 18'sd0) begin
            if (y18 < rs) begin
              cls_next.hit = 1'b1;
              cls_next.point = 1'b1;
            end
          end else if (y18 <= ly18) begin
            if (dv18 > nr) begin
              cls_next.hit = 1'b1;
              cls_next.point = 1'b1;
              cls_next.dy = dv;
            end
          end else begin
            cls_next.hit = 1'b1;
            cls_next.base_x = 16'(cx18 + nr - x18);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (en0) v0 <= in_valid;
      if (en1) v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) geo <= geo_next;
    if (en1) cls <= cls_next;
  end

endmodule

// File: hdl/cscp_length.sv
// octagonal length, push test and dividend setup, three stages
module cscp_length (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [cscp_pkg::RW-1:0]  radius,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  cscp_pkg::cls_t           in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output cscp_pkg::div_t           out_data
);

  cscp_pkg::st_t  st;
  cscp_pkg::st_t  st_next;
  cscp_pkg::len_t ln;
  cscp_pkg::len_t ln_next;
  cscp_pkg::div_t dv;
  cscp_pkg::div_t dv_next;
  logic v0, v1, v2;
  logic en0, en1, en2;

  logic signed [16:0] dx17, dy17, ax17, ay17;
  logic [cscp_pkg::LW-1:0] s_w, t_w, p15, p34, dabs, rlim;
  logic [cscp_pkg::RW:0] rp4;
  logic [27:0] prod_x, prod_y;

  assign en2 = !v2 || out_ready;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;
  assign in_ready = en0;
  assign out_valid = v2;
  assign out_data = dv;

  // magnitudes, sum and difference
  always_comb begin
    dx17 = 17'(in_data.dx);
    dy17 = 17'(in_data.dy);
    ax17 = (dx17 < 17'sd0) ? -dx17 : dx17;
    ay17 = (dy17 < 17'sd0) ? -dy17 : dy17;
    st_next.c = in_data;
    st_next.a = ax17[15:0];
    st_next.b = ay17[15:0];
    st_next.s = {1'b0, ax17[15:0]} + {1'b0, ay17[15:0]};
    st_next.t = (ax17[15:0] >= ay17[15:0]) ? ax17[15:0] - ay17[15:0]
                                           : ay17[15:0] - ax17[15:0];
  end

  // s*164 + t*72 + |15s - 34t|
  always_comb begin
    s_w = cscp_pkg::LW'(st.s);
    t_w = cscp_pkg::LW'(st.t);
    p15 = s_w * cscp_pkg::K_S2;
    p34 = t_w * cscp_pkg::K_T2;
    dabs = (p15 >= p34) ? p15 - p34 : p34 - p15;
    ln_next.c = st.c;
    ln_next.a = st.a;
    ln_next.b = st.b;
    ln_next.len = s_w * cscp_pkg::K_S + t_w * cscp_pkg::K_T + dabs;
  end

  // push window and scaled dividends
  always_comb begin
    rlim = cscp_pkg::LW'({radius, 8'b0});
    rp4 = {1'b0, radius} + cscp_pkg::PUSH_PAD;
    prod_x = 28'(ln.a) * 28'(rp4);
    prod_y = 28'(ln.b) * 28'(rp4);
    dv_next.hit = ln.c.hit;
    dv_next.push = ln.c.point && (ln.len < rlim) && (ln.len >= cscp_pkg::LEN_MIN);
    dv_next.base_x = ln.c.base_x;
    dv_next.base_y = ln.c.base_y;
    dv_next.dx = ln.c.dx;
    dv_next.dy = ln.c.dy;
    dv_next.rem_x = {prod_x[22:0], 8'b0};
    dv_next.rem_y = {prod_y[22:0], 8'b0};
    dv_next.den = ln.len[cscp_pkg::DW-1:0];
    dv_next.q_x = '0;
    dv_next.q_y = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en0) v0 <= in_valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) st <= st_next;
    if (en1) ln <= ln_next;
    if (en2) dv <= dv_next;
  end

endmodule

// File: hdl/cscp_divider.sv
// restoring divider, one quotient bit per stage for both axes
module cscp_divider (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cscp_pkg::div_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cscp_pkg::div_t out_data
);

  localparam int QW = cscp_pkg::QW;
  localparam int NW = cscp_pkg::NW;

  cscp_pkg::div_t st [QW];
  cscp_pkg::div_t st_next [QW];
  logic [QW-1:0] v;
  logic [QW-1:0] en;

  always_comb begin
    en[QW-1] = !v[QW-1] || out_ready;
    for (int i = QW - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_ready = en[0];
  assign out_valid = v[QW-1];
  assign out_data = st[QW-1];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int K = QW - 1 - i;
    cscp_pkg::div_t src;
    logic [NW:0] dsh;

    if (i == 0) begin : g_first
      assign src = in_data;
    end else begin : g_rest
      assign src = st[i-1];
    end

    always_comb begin
      dsh = (NW+1)'(src.den) << K;
      st_next[i] = src;
      if ({1'b0, src.rem_x} >= dsh) begin
        st_next[i].rem_x = src.rem_x - dsh[NW-1:0];
        st_next[i].q_x[K] = 1'b1;
      end
      if ({1'b0, src.rem_y} >= dsh) begin
        st_next[i].rem_y = src.rem_y - dsh[NW-1:0];
        st_next[i].q_y[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en[i]) begin
        v[i] <= (i == 0) ? in_valid : v[(i == 0) ? 0 : i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) st[i] <= st_next[i];
    end
  end

endmodule

// File: hdl/circle_segment_collision_pushout_top.sv
// top level: circle against axis-aligned wall collision with push-out
// One wall test enters per cycle unless the output stalls it back: two
// stages form the wall offsets and classify the hit, three stages build the
// octagonal endpoint length and the scaled dividends, twelve stages of a
// restoring divider produce one quotient bit each for x and y, and an output
// register applies the push. Every stage moves on its own valid bit, so a
// stalled output only holds back stages that are full and input beats keep
// flowing into bubbles. radius is written through the cfg channel, which is
// always ready; write it only while no beat is in flight.
module circle_segment_collision_pushout_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [10:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cscp_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cscp_pkg::out_beat_t  out_data
);

  // collision radius register
  logic [cscp_pkg::RW-1:0] radius;

  // stage links
  logic           cls_valid, cls_ready;
  cscp_pkg::cls_t cls_data;
  logic           len_valid, len_ready;
  cscp_pkg::div_t len_data;
  logic           div_valid, div_ready;
  cscp_pkg::div_t div_data;

  // final adjust
  logic signed [16:0] qx17, qy17, sx17, sy17, bx17, by17, dx17, dy17;
  cscp_pkg::out_beat_t res_next;
  cscp_pkg::out_beat_t res;
  logic out_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= cscp_pkg::RADIUS_RST;
    end else if (cfg_valid) begin
      radius <= cfg_data;
    end
  end

  cscp_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .radius    (radius),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (cls_valid),
    .out_ready (cls_ready),
    .out_data  (cls_data)
  );

  cscp_length u_length (
    .clk       (clk),
    .rst       (rst),
    .radius    (radius),
    .in_valid  (cls_valid),
    .in_ready  (cls_ready),
    .in_data   (cls_data),
    .out_valid (len_valid),
    .out_ready (len_ready),
    .out_data  (len_data)
  );

  cscp_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (len_valid),
    .in_ready  (len_ready),
    .in_data   (len_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  // quotient is a magnitude; restore the sign of the offset, then
  // replace the offset by the scaled one
  always_comb begin
    qx17 = $signed({5'b0, div_data.q_x});
    qy17 = $signed({5'b0, div_data.q_y});
    dx17 = 17'(div_data.dx);
    dy17 = 17'(div_data.dy);
    bx17 = 17'(div_data.base_x);
    by17 = 17'(div_data.base_y);
    sx17 = (dx17 < 17'sd0) ? -qx17 : qx17;
    sy17 = (dy17 < 17'sd0) ? -qy17 : qy17;
    res_next.hit = div_data.hit;
    if (div_data.push) begin
      res_next.new_x = 16'(bx17 + sx17 - dx17);
      res_next.new_y = 16'(by17 + sy17 - dy17);
    end else begin
      res_next.new_x = div_data.base_x;
      res_next.new_y = div_data.base_y;
    end
  end

  // output register: takes a new beat whenever it is empty or drained
  assign out_en = !out_valid || out_ready;
  assign div_ready = out_en;
  assign out_data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) res <= res_next;
  end

  // a push only ever follows an endpoint hit
  a_push_hit: assert property (@(posedge clk) disable iff (rst)
    div_valid && div_data.push |-> div_data.hit)
    else $error("push without hit");

  // the quotient fits, so the divider leaves a remainder below the divisor
  a_rem_x: assert property (@(posedge clk) disable iff (rst)
    div_valid && div_data.push |-> div_data.rem_x < cscp_pkg::NW'(div_data.den))
    else $error("divider remainder x out of range");

  a_rem_y: assert property (@(posedge clk) disable iff (rst)
    div_valid && div_data.push |-> div_data.rem_y < cscp_pkg::NW'(div_data.den))
    else $error("divider remainder y out of range");

  // an empty output register lets the whole pipe advance
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

// File: tb/circle_segment_collision_pushout_top_tb.sv
// testbench for the circle versus wall push-out pipeline, self-checking
`timescale 1ns / 1ps

module circle_segment_collision_pushout_top_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;   // pipeline is 18 deep, leave margin

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [10:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  cscp_pkg::in_beat_t   in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  cscp_pkg::out_beat_t  out_data;

  circle_segment_collision_pushout_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // walls waiting to be sent and positions still owed by the block
  cscp_pkg::in_beat_t  wall_queue[$];
  cscp_pkg::out_beat_t pos_queue[$];
  logic [10:0] radius_now = cscp_pkg::RADIUS_RST;   // radius the block holds
  bit          quiet = 1'b0;              // no idling in the last stretch
  logic        hold_req = 1'b0;           // asks the monitor for a long stall
  int          errors = 0;
  int          cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // pushes an endpoint-relative offset out to radius+4 when the length allows
  function automatic void corner_push(input int dx, input int dy, input int r,
                                      inout int px, inout int py);
    int a, b, s, t, len;
    longint scale;
    a = dx < 0 ? -dx : dx;
    b = dy < 0 ? -dy : dy;
    s = a + b;
    t = (a > b) ? a - b : b - a;
    len = s * 164 + t * 72 + ((s * 15 - t * 34) < 0 ? t * 34 - s * 15 : s * 15 - t * 34);
    if (len < r * 256 && len >= 256) begin
      scale = longint'(r + 4) * 256;
      px += int'((longint'(dx) * scale) / len) - dx;
      py += int'((longint'(dy) * scale) / len) - dy;
    end
  endfunction

  // expected corrected position for one wall test
  function automatic cscp_pkg::out_beat_t pushout_pos(input cscp_pkg::in_beat_t w,
                                                      input logic [10:0] rad);
    int cx, cy, sx, sy, ex, ey, r, xp, yp, lx, ly, nx, ny, d;
    cscp_pkg::out_beat_t o;
    cx = int'(w.cam_x);
    cy = int'(w.cam_y);
    sx = int'(w.start_x);
    sy = int'(w.start_y);
    ex = int'(w.end_x);
    ey = int'(w.end_y);
    r  = int'({1'b0, rad});
    xp = int'(shortint'(cx - sx * 16));
    yp = int'(shortint'(cy - sy * 16));
    lx = int'(shortint'((ex - sx) * 16));
    ly = int'(shortint'((ey - sy) * 16));
    nx = cx;
    ny = cy;
    o.hit = 1'b0;
    if (ly == 0) begin
      // horizontal wall, zero length lands here too
      if (!(yp <= -r || yp >= r)) begin
        if (lx > 0) begin
          if (xp <= 0) begin
            if (xp > -r) begin o.hit = 1'b1; corner_push(xp, yp, r, nx, ny); end
          end else if (xp >= lx) begin
            d = int'(shortint'(xp - lx));
            if (d < r) begin o.hit = 1'b1; corner_push(d, yp, r, nx, ny); end
          end else begin
            ny += -r - yp;
            o.hit = 1'b1;
          end
        end else begin
          if (xp >= 0) begin
            if (xp < r) begin o.hit = 1'b1; corner_push(xp, yp, r, nx, ny); end
          end else if (xp <= lx) begin
            d = int'(shortint'(xp - lx));
            if (d > -r) begin o.hit = 1'b1; corner_push(d, yp, r, nx, ny); end
          end else begin
            ny += r - yp;
            o.hit = 1'b1;
          end
        end
      end
    end else if (lx == 0) begin
      // vertical wall
      if (!(xp <= -r || xp >= r)) begin
        if (ly > 0) begin
          if (yp <= 0) begin
            if (yp > -r) begin o.hit = 1'b1; corner_push(xp, yp, r, nx, ny); end
          end else if (yp >= ly) begin
            d = int'(shortint'(yp - ly));
            if (d < r) begin o.hit = 1'b1; corner_push(xp, d, r, nx, ny); end
          end else begin
            nx += r - xp;
            o.hit = 1'b1;
          end
        end else begin
          if (yp >= 0) begin
            if (yp < r) begin o.hit = 1'b1; corner_push(xp, yp, r, nx, ny); end
          end else if (yp <= ly) begin
            d = int'(shortint'(yp - ly));
            if (d > -r) begin o.hit = 1'b1; corner_push(xp, d, r, nx, ny); end
          end else begin
            nx += -r - xp;
            o.hit = 1'b1;
          end
        end
      end
    end
    o.new_x = 16'(nx);
    o.new_y = 16'(ny);
    return o;
  endfunction

  function automatic cscp_pkg::in_beat_t wall_at(input int cx, input int cy, input int sx,
                                                 input int sy, input int ex, input int ey);
    cscp_pkg::in_beat_t w;
    w.cam_x   = 16'(cx);
    w.cam_y   = 16'(cy);
    w.start_x = 12'(sx);
    w.start_y = 12'(sy);
    w.end_x   = 12'(ex);
    w.end_y   = 12'(ey);
    return w;
  endfunction

  // camera placed around an axis wall so most tests land in the radius band
  function automatic cscp_pkg::in_beat_t near_wall(input int r);
    int kind, sx, sy, len, alen, lo, along, perp;
    cscp_pkg::in_beat_t w;
    kind = $urandom_range(0, 9);
    if (kind >= 8 && $urandom_range(0, 5) == 0) begin
      // plain noise, any bit pattern
      w = cscp_pkg::in_beat_t'({$urandom, $urandom, $urandom});
      return w;
    end
    sx = int'($urandom_range(0, 4095)) - 2048;
    sy = int'($urandom_range(0, 4095)) - 2048;
    len = int'($urandom_range(0, 48)) - 24;
    if (kind == 8) len = 0;
    alen = len < 0 ? -len : len;
    lo = len < 0 ? len * 16 : 0;
    along = int'($urandom_range(0, alen * 16 + 2 * r + 40)) - r - 20 + lo;
    perp = int'($urandom_range(0, 2 * r + 8)) - r - 4;
    if (kind < 4 || kind == 8)
      w = wall_at(sx * 16 + along, sy * 16 + perp, sx, sy, sx + len, sy);
    else if (kind < 8)
      w = wall_at(sx * 16 + perp, sy * 16 + along, sx, sy, sx, sy + len);
    else
      w = wall_at(sx * 16 + perp, sy * 16 + along, sx, sy, sx + len, sy + 1 + alen);
    return w;
  endfunction

  // driver: feeds walls from the queue, random gaps between beats
  always @(posedge clk) begin
    int gap;
    logic               nxt_valid;
    cscp_pkg::in_beat_t nxt_data;
    if (rst) begin
      gap = 0;
    end else begin
      nxt_valid = in_valid;
      nxt_data  = in_data;
      if (in_valid && in_ready) begin
        pos_queue.push_back(pushout_pos(in_data, radius_now));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap > 0) begin
          gap--;
        end else if (wall_queue.size() > 0) begin
          if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
          end else begin
            nxt_valid = 1'b1;
            nxt_data  = wall_queue.pop_front();
          end
        end
      end
      in_valid <= nxt_valid;
      in_data  <= nxt_data;
    end
  end

  // monitor: random stalls, one long stall on request, checks every beat
  always @(posedge clk) begin
    int stall;
    bit long_done;
    cscp_pkg::out_beat_t want;
    logic nxt_ready;
    if (rst) begin
      stall = 0;
      long_done = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pos_queue.size() == 0) begin
          $error("result beat with nothing expected: hit=%0d x=%0d y=%0d",
                 out_data.hit, out_data.new_x, out_data.new_y);
          errors++;
        end else begin
          want = pos_queue.pop_front();
          if (out_data.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, out_data.hit);
            errors++;
          end
          if (out_data.new_x !== want.new_x) begin
            $error("new_x: expected %0d, got %0d", want.new_x, out_data.new_x);
            errors++;
          end
          if (out_data.new_y !== want.new_y) begin
            $error("new_y: expected %0d, got %0d", want.new_y, out_data.new_y);
            errors++;
          end
        end
      end
      // long hold so the pipeline fills and backs up the input
      if (hold_req && !long_done) begin
        long_done = 1'b1;
        stall = 300;
      end
      if (stall > 0) begin
        stall--;
        nxt_ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 7);
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      out_ready <= nxt_ready;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // wait until every wall is sent and every result checked, then settle;
  // sampled at the falling edge so the driver's updates have all landed
  task automatic drain();
    while (wall_queue.size() > 0 || in_valid || pos_queue.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_radius(input logic [10:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    radius_now = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_walls(input int count);
    for (int i = 0; i < count; i++) wall_queue.push_back(near_wall(int'(radius_now)));
  endtask

  initial begin
    logic [10:0] rad_set[$];
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed walls at the reset radius of 240
    wall_queue.push_back(wall_at(32767, 32767, 2047, 2047, 2047, 2047));
    wall_queue.push_back(wall_at(-32768, -32768, -2048, -2048, -2048, -2048));
    wall_queue.push_back(wall_at(32767, -32768, -2048, 2047, 2047, 2047));
    wall_queue.push_back(wall_at(-32768, 32767, 2047, -2048, 2047, -2048));
    // horizontal body, both directions
    wall_queue.push_back(wall_at(32, 10, 0, 0, 4, 0));
    wall_queue.push_back(wall_at(-32, -10, 0, 0, -4, 0));
    // vertical body, both directions
    wall_queue.push_back(wall_at(10, 32, 0, 0, 0, 4));
    wall_queue.push_back(wall_at(-10, -32, 0, 0, 0, -4));
    // beyond the far and near ends, pushed out from the endpoint
    wall_queue.push_back(wall_at(100, 60, 0, 0, 4, 0));
    wall_queue.push_back(wall_at(-80, -50, 0, 0, 4, 0));
    wall_queue.push_back(wall_at(50, 120, 0, 0, 0, 4));
    wall_queue.push_back(wall_at(-40, -100, 0, 0, 0, -4));
    // camera on the endpoint: hit with length too small to push
    wall_queue.push_back(wall_at(16, 16, 1, 1, 5, 1));
    // zero-length wall around one point
    wall_queue.push_back(wall_at(85, 85, 5, 5, 5, 5));
    // on the radius band edge, no hit, then just inside it, a hit
    wall_queue.push_back(wall_at(32, 240, 0, 0, 4, 0));
    wall_queue.push_back(wall_at(239, 32, 0, 0, 0, 4));
    // diagonal wall never hits
    wall_queue.push_back(wall_at(16, 16, 0, 0, 3, 3));
    // offsets that wrap past 16 bits
    wall_queue.push_back(wall_at(-32760, 0, 2047, 0, -2048, 0));
    random_walls(130);
    drain();

    // extremes and other settings, sender idle between phases
    rad_set = '{11'd16, 11'd1024, 11'd0, 11'd2047, 11'd100};
    for (int p = 0; p < 10; p++) begin
      if (p < rad_set.size()) write_radius(rad_set[p]);
      else write_radius(11'($urandom_range(16, 1024)));
      if (p == 9) quiet = 1'b1;
      if (p == 1) begin
        random_walls(50);
        @(posedge clk);
        hold_req <= 1'b1;
      end
      random_walls(p == 2 ? 60 : 100);
      drain();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: circle_segment_collision_pushout_top.f
hdl/cscp_pkg.sv
hdl/cscp_classify.sv
hdl/cscp_length.sv
hdl/cscp_divider.sv
hdl/circle_segment_collision_pushout_top.sv
tb/circle_segment_collision_pushout_top_tb.sv
